>>> rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("check failed");
`define CHK_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("check failed");
`endif

>>> rtl/ibc_pkg.sv
package ibc_pkg;
  localparam int unsigned NV = 1024;
  localparam int unsigned VW = 10;
  localparam int unsigned PW = 11;
  localparam int unsigned SB = 16;
  localparam logic [PW-1:0] NO_V = PW'(NV);

  typedef struct packed {
    logic [9:0] end_a;
    logic [9:0] end_b;
  } ibc_in_t;

  typedef struct packed {
    logic [9:0] bridge_count;
    logic       became_bridge;
    logic [9:0] bridges_removed;
    logic       edge_ignored;
    logic       range_error;
  } ibc_out_t;

  typedef enum logic [5:0] {
    S_CLR, S_IDLE,
    S_R2_RD, S_R2_CHK, S_R2_CMP_RD, S_R2_CMP,
    S_DISPATCH,
    S_RC_RD, S_RC_CHK, S_RC_CMP_RD, S_RC_CMP,
    S_SZ_RD, S_SZ_GET,
    S_RR_RD, S_RR_GET, S_RR_UP,
    S_ST_CLR,
    S_CA_RD, S_CA_GET, S_CA_PAR_RD, S_CA_PAR,
    S_MU_RD, S_MU_GET, S_MU_UP,
    S_OUT
  } ibc_state_t;

  // what the rep2 walk returns to
  typedef enum logic [3:0] {
    RET_U, RET_V, RET_RC_U, RET_RC_V, RET_RR_START, RET_RR_UP,
    RET_CA, RET_MU_UP
  } ibc_ret_t;
endpackage

>>> rtl/ibc_ram.sv
module ibc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/incremental_bridge_count.sv
// channel  | direction | handshake             | payload
// in_      | input     | in_valid / in_stall   | ibc_in_t (end_a, end_b)
// out_     | output    | out_valid / out_stall | ibc_out_t
// one item at a time; each item runs union-find root searches, each followed by compression
// of the nodes it walked, and each forest step is a parent read plus a rep2 walk, so the time
// taken for an item is set by the chain and path lengths it walks.
// after reset a clearing pass over all 1024 addresses initialises all memories before in_stall
// drops; a stamp wrap triggers another sweep of the visit stamps.
// a result is held in the output register until out_stall is low; the next item may be
// taken meanwhile and waits in S_OUT for the register to free up.
module incremental_bridge_count import ibc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ibc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output ibc_out_t out_data
);
  ibc_state_t st_r, st_nxt;
  ibc_ret_t ret_r, ret_nxt;
  logic [VW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] x_r, x_nxt, r_r, r_nxt, w_r, w_nxt;
  logic [VW-1:0] u_r, u_nxt, v_r, v_nxt, cu_r, cu_nxt, cv_r, cv_nxt, top_r, top_nxt;
  logic [PW-1:0] below_r, below_nxt, cur_r, cur_nxt, b_r, b_nxt;
  logic [PW-1:0] szu_r, szu_nxt;
  logic [SB-1:0] stamp_r, stamp_nxt;
  logic [VW-1:0] total_r, total_nxt, rem_r, rem_nxt;
  logic          side_r, side_nxt, lastu_r, lastu_nxt;
  logic          rc_r, rc_nxt;
  logic          ov_r, ov_nxt;
  ibc_out_t      od_r, od_nxt;
  ibc_out_t      res_r, res_nxt;

  logic          fp_we, tr_we, cr_we, cs_we, vs_we;
  logic [VW-1:0] fp_wa, tr_wa, cr_wa, cs_wa, vs_wa;
  logic [VW-1:0] fp_ra, tr_ra, cr_ra, cs_ra, vs_ra;
  logic [PW-1:0] fp_wd, fp_rd, cs_wd, cs_rd;
  logic [VW-1:0] tr_wd, tr_rd, cr_wd, cr_rd;
  logic [SB-1:0] vs_wd, vs_rd;

  ibc_ram #(.WIDTH(PW), .DEPTH(NV)) u_fp (.clk, .we(fp_we), .waddr(fp_wa), .wdata(fp_wd),
    .raddr(fp_ra), .rdata(fp_rd));
  ibc_ram #(.WIDTH(VW), .DEPTH(NV)) u_tr (.clk, .we(tr_we), .waddr(tr_wa), .wdata(tr_wd),
    .raddr(tr_ra), .rdata(tr_rd));
  ibc_ram #(.WIDTH(VW), .DEPTH(NV)) u_cr (.clk, .we(cr_we), .waddr(cr_wa), .wdata(cr_wd),
    .raddr(cr_ra), .rdata(cr_rd));
  ibc_ram #(.WIDTH(PW), .DEPTH(NV)) u_cs (.clk, .we(cs_we), .waddr(cs_wa), .wdata(cs_wd),
    .raddr(cs_ra), .rdata(cs_rd));
  ibc_ram #(.WIDTH(SB), .DEPTH(NV)) u_vs (.clk, .we(vs_we), .waddr(vs_wa), .wdata(vs_wd),
    .raddr(vs_ra), .rdata(vs_rd));

  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      cnt_r <= '0;
      ov_r <= 1'b0;
      stamp_r <= '0;
      total_r <= '0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      ov_r <= ov_nxt;
      stamp_r <= stamp_nxt;
      total_r <= total_nxt;
    end
    ret_r <= ret_nxt; x_r <= x_nxt; r_r <= r_nxt; w_r <= w_nxt;
    u_r <= u_nxt; v_r <= v_nxt; cu_r <= cu_nxt; cv_r <= cv_nxt; top_r <= top_nxt;
    below_r <= below_nxt; cur_r <= cur_nxt; b_r <= b_nxt; szu_r <= szu_nxt;
    rem_r <= rem_nxt; side_r <= side_nxt; lastu_r <= lastu_nxt; rc_r <= rc_nxt;
    od_r <= od_nxt; res_r <= res_nxt;
  end

  // next-state logic; a rep2 (or repc when rc set) walk runs on value x
  always_comb begin
    st_nxt = st_r; ret_nxt = ret_r; cnt_nxt = cnt_r;
    x_nxt = x_r; r_nxt = r_r; w_nxt = w_r;
    u_nxt = u_r; v_nxt = v_r; cu_nxt = cu_r; cv_nxt = cv_r; top_nxt = top_r;
    below_nxt = below_r; cur_nxt = cur_r; b_nxt = b_r; szu_nxt = szu_r;
    stamp_nxt = stamp_r; total_nxt = total_r; rem_nxt = rem_r;
    side_nxt = side_r; lastu_nxt = lastu_r; rc_nxt = rc_r;
    ov_nxt = ov_r; od_nxt = od_r; res_nxt = res_r;
    fp_we = 1'b0; tr_we = 1'b0; cr_we = 1'b0; cs_we = 1'b0; vs_we = 1'b0;
    fp_wa = '0; tr_wa = '0; cr_wa = '0; cs_wa = '0; vs_wa = '0;
    fp_wd = NO_V; tr_wd = '0; cr_wd = '0; cs_wd = PW'(1); vs_wd = '0;
    fp_ra = '0; tr_ra = '0; cr_ra = '0; cs_ra = '0; vs_ra = '0;

    if (ov_r && !out_stall) ov_nxt = 1'b0;

    case (st_r)
      S_CLR: begin
        fp_we = 1'b1; tr_we = 1'b1; cr_we = 1'b1; cs_we = 1'b1; vs_we = 1'b1;
        fp_wa = cnt_r; tr_wa = cnt_r; cr_wa = cnt_r; cs_wa = cnt_r; vs_wa = cnt_r;
        tr_wd = cnt_r; cr_wd = cnt_r;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == VW'(NV - 1)) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          u_nxt = in_data.end_a;
          v_nxt = in_data.end_b;
          rem_nxt = '0;
          res_nxt = '0;
          if (!(32'(in_data.end_a) < NV && 32'(in_data.end_b) < NV)) begin
            res_nxt.range_error = 1'b1;
            st_nxt = S_OUT;
          end else begin
            x_nxt = {1'b0, in_data.end_a}; rc_nxt = 1'b0; ret_nxt = RET_U;
            st_nxt = S_R2_RD;
          end
        end
      end
      // root search: r follows the chain
      S_R2_RD: begin
        r_nxt = x_r;
        if (rc_r) cr_ra = x_r[VW-1:0]; else tr_ra = x_r[VW-1:0];
        st_nxt = S_R2_CHK;
      end
      S_R2_CHK: begin
        if ((rc_r ? cr_rd : tr_rd) == r_r[VW-1:0]) begin
          w_nxt = x_r;
          st_nxt = S_R2_CMP_RD;
        end else begin
          r_nxt = {1'b0, rc_r ? cr_rd : tr_rd};
          if (rc_r) cr_ra = rc_r ? cr_rd : tr_rd; else tr_ra = tr_rd;
          st_nxt = S_R2_CHK;
        end
      end
      // compression: point every node of the chain at the root
      S_R2_CMP_RD: begin
        if (w_r == r_r) begin
          st_nxt = S_DISPATCH;
        end else begin
          if (rc_r) cr_ra = w_r[VW-1:0]; else tr_ra = w_r[VW-1:0];
          st_nxt = S_R2_CMP;
        end
      end
      S_R2_CMP: begin
        if (rc_r) begin
          cr_we = 1'b1; cr_wa = w_r[VW-1:0]; cr_wd = r_r[VW-1:0];
          w_nxt = {1'b0, cr_rd};
        end else begin
          tr_we = 1'b1; tr_wa = w_r[VW-1:0]; tr_wd = r_r[VW-1:0];
          w_nxt = {1'b0, tr_rd};
        end
        st_nxt = S_R2_CMP_RD;
      end
      S_DISPATCH: begin
        case (ret_r)
          RET_U: begin
            u_nxt = r_r[VW-1:0];
            x_nxt = {1'b0, v_r}; ret_nxt = RET_V; st_nxt = S_R2_RD;
          end
          RET_V: begin
            v_nxt = r_r[VW-1:0];
            if (r_r[VW-1:0] == u_r) begin
              res_nxt.edge_ignored = 1'b1; st_nxt = S_OUT;
            end else begin
              x_nxt = {1'b0, u_r}; rc_nxt = 1'b1; ret_nxt = RET_RC_U; st_nxt = S_R2_RD;
            end
          end
          RET_RC_U: begin
            cu_nxt = r_r[VW-1:0];
            x_nxt = {1'b0, v_r}; ret_nxt = RET_RC_V; st_nxt = S_R2_RD;
          end
          RET_RC_V: begin
            cv_nxt = r_r[VW-1:0];
            rc_nxt = 1'b0;
            if (r_r[VW-1:0] != cu_r) begin
              st_nxt = S_SZ_RD;
            end else begin
              // fresh stamp for the ancestor search
              if (stamp_r + 1'b1 == '0) begin
                stamp_nxt = SB'(1); cnt_nxt = '0; st_nxt = S_ST_CLR;
              end else begin
                stamp_nxt = stamp_r + 1'b1; st_nxt = S_CA_RD;
              end
              cur_nxt = {1'b0, u_r}; b_nxt = {1'b0, v_r};
            end
          end
          RET_RR_START: begin
            cur_nxt = r_r; below_nxt = NO_V; st_nxt = S_RR_RD;
          end
          RET_RR_UP: begin
            cur_nxt = r_r; st_nxt = S_RR_RD;
          end
          RET_CA: begin
            cur_nxt = r_r; st_nxt = S_CA_GET;
            vs_ra = r_r[VW-1:0];
          end
          RET_MU_UP: begin
            cur_nxt = r_r; st_nxt = S_MU_RD;
          end
          default: st_nxt = S_IDLE;
        endcase
      end
      S_SZ_RD: begin
        cs_ra = cu_r; st_nxt = S_SZ_GET; side_nxt = 1'b0;
      end
      S_SZ_GET: begin
        if (!side_r) begin
          szu_nxt = cs_rd; cs_ra = cv_r; side_nxt = 1'b1;
        end else begin
          cs_we = 1'b1;
          if (szu_r > cs_rd) begin
            u_nxt = v_r; v_nxt = u_r; cu_nxt = cv_r; cv_nxt = cu_r;
            cs_wa = cu_r;
          end else begin
            cs_wa = cv_r;
          end
          cs_wd = szu_r + cs_rd;
          total_nxt = total_r + 1'b1;
          x_nxt = (szu_r > cs_rd) ? {1'b0, v_r} : {1'b0, u_r};
          ret_nxt = RET_RR_START; st_nxt = S_R2_RD;
        end
      end
      // reroot: reverse the parent chain from u to its root
      S_RR_RD: begin
        if (cur_r == NO_V) begin
          fp_we = 1'b1; fp_wa = u_r; fp_wd = {1'b0, v_r};
          cr_we = 1'b1; cr_wa = cu_r; cr_wd = cv_r;
          res_nxt.became_bridge = 1'b1;
          st_nxt = S_OUT;
        end else begin
          fp_ra = cur_r[VW-1:0]; st_nxt = S_RR_GET;
        end
      end
      S_RR_GET: begin
        fp_we = 1'b1; fp_wa = cur_r[VW-1:0]; fp_wd = below_r;
        below_nxt = cur_r;
        if (fp_rd == NO_V) begin
          cur_nxt = NO_V; st_nxt = S_RR_RD;
        end else begin
          x_nxt = fp_rd; ret_nxt = RET_RR_UP; st_nxt = S_R2_RD;
        end
      end
      S_ST_CLR: begin
        vs_we = 1'b1; vs_wa = cnt_r; vs_wd = '0;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == VW'(NV - 1)) st_nxt = S_CA_RD;
      end
      // alternate between the two climbing ends
      S_CA_RD: begin
        if (cur_r == NO_V) begin
          cur_nxt = b_r; b_nxt = cur_r; st_nxt = S_CA_RD;
        end else begin
          x_nxt = cur_r; ret_nxt = RET_CA; st_nxt = S_R2_RD;
        end
      end
      S_CA_GET: begin
        if (vs_rd == stamp_r) begin
          top_nxt = cur_r[VW-1:0];
          cur_nxt = {1'b0, u_r}; lastu_nxt = 1'b0; st_nxt = S_MU_RD;
        end else begin
          vs_we = 1'b1; vs_wa = cur_r[VW-1:0]; vs_wd = stamp_r;
          fp_ra = cur_r[VW-1:0]; st_nxt = S_CA_PAR;
        end
      end
      S_CA_PAR: begin
        cur_nxt = b_r; b_nxt = fp_rd; st_nxt = S_CA_RD;
      end
      S_CA_PAR_RD: st_nxt = S_CA_RD;
      // merge each step of the path into the ancestor
      S_MU_RD: begin
        if (cur_r == NO_V || cur_r[VW-1:0] == top_r) begin
          if (!lastu_r) begin
            lastu_nxt = 1'b1; cur_nxt = {1'b0, v_r};
          end else begin
            res_nxt.bridges_removed = rem_r; st_nxt = S_OUT;
          end
        end else begin
          fp_ra = cur_r[VW-1:0]; st_nxt = S_MU_GET;
        end
      end
      S_MU_GET: begin
        tr_we = 1'b1; tr_wa = cur_r[VW-1:0]; tr_wd = top_r;
        total_nxt = total_r - 1'b1; rem_nxt = rem_r + 1'b1;
        if (fp_rd == NO_V) begin
          cur_nxt = NO_V; st_nxt = S_MU_RD;
        end else begin
          x_nxt = fp_rd; ret_nxt = RET_MU_UP; st_nxt = S_R2_RD;
        end
      end
      S_MU_UP, S_RR_UP: st_nxt = S_IDLE;
      // wait here while the previous result is still held
      S_OUT: begin
        if (!ov_r || !out_stall) begin
          od_nxt = res_r;
          od_nxt.bridge_count = total_r;
          ov_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end
endmodule

>>> rtl/ibc_checker.sv
`include "assert_macros.svh"
module ibc_checker import ibc_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input ibc_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input ibc_out_t out_data
);
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  `CHK_IMPL(a_flags_excl, clk, rst_n, out_valid,
    $countones({out_data.became_bridge, out_data.edge_ignored, out_data.range_error}) <= 1)
  `CHK_IMPL(a_rem_only_cycle, clk, rst_n, out_valid && out_data.bridges_removed != '0,
    !out_data.became_bridge && !out_data.edge_ignored && !out_data.range_error)
  `CHK_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
endmodule

bind incremental_bridge_count ibc_checker u_chk (.*);
